// File: hw/rtl/bid_pkg.sv
package bid_pkg;

	// Default build parameters.
	localparam int ADC_BITS_DEF  = 12;
	localparam int PWM_BITS_DEF  = 10;
	localparam int TICK_BITS_DEF = 32;

	// Fixed field and register widths.
	localparam int PCT_W      = 7;
	localparam int LEVEL_W    = 2;
	localparam int TIMEOUT_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Full scale of a percentage.
	localparam int PCT_FULL = 100;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_TIMEOUT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_PERCENT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_PERCENT      = 3'd4;

	// Configuration reset values.
	localparam logic [PCT_W-1:0]     THRESHOLD_RST   = 7'd5;
	localparam logic [TIMEOUT_W-1:0] DIM_TIMEOUT_RST = 32'd30000;
	localparam logic [TIMEOUT_W-1:0] OFF_TIMEOUT_RST = 32'd15000;
	localparam logic [PCT_W-1:0]     DIM_PERCENT_RST = 7'd20;
	localparam logic [PCT_W-1:0]     OFF_PERCENT_RST = 7'd0;

	// Idle stage, also reported as the idle level of a result.
	typedef enum logic [LEVEL_W-1:0] {
		LVL_ACTIVE = 2'd0,
		LVL_DIM    = 2'd1,
		LVL_OFF    = 2'd2
	} idle_level_t;

endpackage

// File: hw/rtl/backlight_idle_dimmer.sv
// Backlight idle dimmer.
// A sample is captured in the input register, and its result, when it gives one, in the result register.
// Throughput: one sample per cycle; input register and result register are separate
// stages, so a new sample is taken while a result waits, until both stages are full.
// Reset (arst_n low, asynchronous): no applied reading, active stage, configuration
// registers back to their default values, both stages empty.
module backlight_idle_dimmer #(
	parameter int ADC_BITS  = bid_pkg::ADC_BITS_DEF,
	parameter int PWM_BITS  = bid_pkg::PWM_BITS_DEF,
	parameter int TICK_BITS = bid_pkg::TICK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bid_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Sample input.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ADC_BITS-1:0]             pot_sample,
	input  logic                            user_active,
	input  logic [TICK_BITS-1:0]            sample_time,
	// Result output.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [PWM_BITS-1:0]             duty,
	output logic [bid_pkg::LEVEL_W-1:0]     idle_level,
	output logic [bid_pkg::PCT_W-1:0]       pot_percent
);
	import bid_pkg::*;

	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int PWM_MAX = (1 << PWM_BITS) - 1;
	localparam int PX_W    = ADC_BITS + PCT_W;
	localparam int DX_W    = ADC_BITS + PWM_BITS;
	// Number of shifted terms that sum to a lower bound of x / ADC_MAX.
	localparam int NTERMS  = (DX_W + ADC_BITS - 1) / ADC_BITS;
	// Width for comparing idle time against the timeout sum without wrap.
	localparam int CMP_W   = ((TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W) + 1;

	// Divide by 2^ADC_BITS-1: shifted partial sums give a quotient that is low by
	// at most NTERMS, and the remainder compares fix it up.
	function automatic logic [PWM_BITS-1:0] div_adc_max(input logic [DX_W-1:0] x);
		logic [DX_W-1:0] q;
		logic [DX_W-1:0] r;
		q = '0;
		for (int k = 1; k <= NTERMS; k++) begin
			q = q + (x >> (k * ADC_BITS));
		end
		r = x - ((q << ADC_BITS) - q);
		for (int c = 1; c <= NTERMS + 1; c++) begin
			if (r >= DX_W'(c * ADC_MAX)) begin
				q = q + 1'b1;
			end
		end
		return q[PWM_BITS-1:0];
	endfunction

	// Percent registers above full scale count as full scale.
	function automatic logic [PCT_W-1:0] pct_clip(input logic [PCT_W-1:0] p);
		return (p > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : p;
	endfunction

	// Duty for each percentage, worked out at elaboration.
	logic [PWM_BITS-1:0] duty_lut [0:PCT_FULL];
	for (genvar i = 0; i <= PCT_FULL; i++) begin : g_lut
		assign duty_lut[i] = PWM_BITS'((i * PWM_MAX) / PCT_FULL);
	end

	// Configuration registers.
	logic [PCT_W-1:0]     threshold_q;
	logic [TIMEOUT_W-1:0] dim_timeout_q;
	logic [TIMEOUT_W-1:0] off_timeout_q;
	logic [PCT_W-1:0]     dim_percent_q;
	logic [PCT_W-1:0]     off_percent_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RST;
			dim_timeout_q <= DIM_TIMEOUT_RST;
			off_timeout_q <= OFF_TIMEOUT_RST;
			dim_percent_q <= DIM_PERCENT_RST;
			off_percent_q <= OFF_PERCENT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHANGE_THRESHOLD: threshold_q   <= cfg_data[PCT_W-1:0];
				CFG_DIM_TIMEOUT:      dim_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_OFF_TIMEOUT:      off_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_DIM_PERCENT:      dim_percent_q <= cfg_data[PCT_W-1:0];
				CFG_OFF_PERCENT:      off_percent_q <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage handshake: the input stage moves on whenever the result register is free.
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || advance;

	// Input register.
	logic [ADC_BITS-1:0]  raw_s1;
	logic                 active_s1;
	logic [TICK_BITS-1:0] now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1    <= pot_sample;
			active_s1 <= user_active;
			now_s1    <= sample_time;
		end
	end

	// Tracking state.
	logic                 have_reading_q;
	logic [PCT_W-1:0]     applied_pct_q;
	logic [TICK_BITS-1:0] change_time_q;
	idle_level_t          stage_q;

	// Percentage of the sample; the quotient stays below 2^ADC_BITS, so one
	// folding step is exact.
	logic [PX_W-1:0]  pct_x;
	logic [PX_W-1:0]  pct_q;
	logic [PCT_W-1:0] pct;

	assign pct_x = PX_W'(raw_s1) * PX_W'(PCT_FULL);
	assign pct_q = (pct_x + (pct_x >> ADC_BITS) + PX_W'(1)) >> ADC_BITS;
	assign pct   = pct_q[PCT_W-1:0];

	// Duty that follows the pot directly.
	logic [DX_W-1:0]     duty_x;
	logic [PWM_BITS-1:0] follow_duty;

	assign duty_x      = DX_W'(raw_s1) * DX_W'(PWM_MAX);
	assign follow_duty = div_adc_max(duty_x);

	// Decisions: apply the sample, dim, or switch off.
	logic [PCT_W-1:0]     pct_diff;
	logic                 apply_now;
	logic [TICK_BITS-1:0] idle_time;
	logic [CMP_W-1:0]     off_limit;
	logic                 dim_now;
	logic                 off_now;

	assign pct_diff  = (pct >= applied_pct_q) ? (pct - applied_pct_q) : (applied_pct_q - pct);
	assign apply_now = !have_reading_q || (pct_diff >= threshold_q) || active_s1;
	assign idle_time = now_s1 - change_time_q;
	assign off_limit = CMP_W'(dim_timeout_q) + CMP_W'(off_timeout_q);
	assign dim_now   = (stage_q == LVL_ACTIVE) && (applied_pct_q != '0)
		&& (CMP_W'(idle_time) >= CMP_W'(dim_timeout_q));
	assign off_now   = (stage_q == LVL_DIM) && (CMP_W'(idle_time) >= off_limit);

	logic process;
	assign process = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_reading_q <= 1'b0;
			applied_pct_q  <= '0;
			change_time_q  <= '0;
			stage_q        <= LVL_ACTIVE;
		end else if (process) begin
			if (apply_now) begin
				have_reading_q <= 1'b1;
				applied_pct_q  <= pct;
				change_time_q  <= now_s1;
				stage_q        <= LVL_ACTIVE;
			end else if (dim_now) begin
				stage_q <= LVL_DIM;
			end else if (off_now) begin
				stage_q <= LVL_OFF;
			end
		end
	end

	// Result register.
	logic [PWM_BITS-1:0] duty_q;
	idle_level_t         level_q;
	logic [PCT_W-1:0]    pct_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q && (apply_now || dim_now || off_now);
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			pct_out_q <= pct;
			if (apply_now) begin
				duty_q  <= follow_duty;
				level_q <= LVL_ACTIVE;
			end else if (dim_now) begin
				duty_q  <= duty_lut[pct_clip(dim_percent_q)];
				level_q <= LVL_DIM;
			end else begin
				duty_q  <= duty_lut[pct_clip(off_percent_q)];
				level_q <= LVL_OFF;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign duty        = duty_q;
	assign idle_level  = level_q;
	assign pot_percent = pct_out_q;

endmodule
